### sv/sttw_pkg.sv
// Package for the sync trigger window tracker.
// Holds field widths, register defaults, register indexes, FSM states and the
// command/status bundles shared by the controller and the datapath.
`default_nettype none

package sttw_pkg;

  localparam int OFFS_W      = 24;
  localparam int LIMIT_W     = 4;
  localparam int MISS_W      = 4;
  localparam int IN_TIME_W   = 48;
  localparam int DEV_TIME_W  = 48;
  localparam int SECS_W      = 32;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 80;
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;

  localparam int DEF_TIME_BITS  = 48;
  localparam int DEF_COUNT_BITS = 32;

  localparam logic [OFFS_W-1:0]  RST_OPEN_OFFSET  = 24'd500000;
  localparam logic [OFFS_W-1:0]  RST_CLOSE_OFFSET = 24'd1500000;
  localparam logic [OFFS_W-1:0]  RST_MISS_PERIOD  = 24'd1000000;
  localparam logic [LIMIT_W-1:0] RST_MISS_LIMIT   = 4'd2;

  localparam logic [MISS_W-1:0]  MISS_SAT = '1;

  typedef enum logic [1:0] {
    REG_OPEN_OFFSET  = 2'd0,
    REG_CLOSE_OFFSET = 2'd1,
    REG_MISS_PERIOD  = 2'd2,
    REG_MISS_LIMIT   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOOP,
    ST_EMIT_STOP,
    ST_EMIT_MATCH
  } state_t;

  typedef struct packed {
    logic [OFFS_W-1:0]  open_offset;
    logic [OFFS_W-1:0]  close_offset;
    logic [OFFS_W-1:0]  miss_period;
    logic [LIMIT_W-1:0] miss_limit;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic set_last;
    logic start_session;
    logic stop_session;
    logic miss_step;
    logic match_update;
    logic load_out;
    logic out_mapping;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic started;
    logic trig;
    logic session_on;
    logic error_latched;
    logic past_close;
    logic before_open;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### sv/sttw_regs.sv
// APB configuration registers of the sync trigger window tracker.
// Depends on sttw_pkg for widths, defaults and register indexes.
`default_nettype none

module sttw_regs
  import sttw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_offset  <= RST_OPEN_OFFSET;
      cfg.close_offset <= RST_CLOSE_OFFSET;
      cfg.miss_period  <= RST_MISS_PERIOD;
      cfg.miss_limit   <= RST_MISS_LIMIT;
    end else if (wr_en) begin
      case (idx)
        REG_OPEN_OFFSET:  cfg.open_offset  <= pwdata[OFFS_W-1:0];
        REG_CLOSE_OFFSET: cfg.close_offset <= pwdata[OFFS_W-1:0];
        REG_MISS_PERIOD:  cfg.miss_period  <= pwdata[OFFS_W-1:0];
        REG_MISS_LIMIT:   cfg.miss_limit   <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_OPEN_OFFSET:  prdata = APB_DATA_W'(cfg.open_offset);
      REG_CLOSE_OFFSET: prdata = APB_DATA_W'(cfg.close_offset);
      REG_MISS_PERIOD:  prdata = APB_DATA_W'(cfg.miss_period);
      REG_MISS_LIMIT:   prdata = APB_DATA_W'(cfg.miss_limit);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### sv/sttw_ctrl.sv
// Controller FSM of the sync trigger window tracker.
// Depends on sttw_pkg for the state enum and the command/status bundles.
`default_nettype none

module sttw_ctrl
  import sttw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.op) begin
          if (sts.started && !sts.session_on) begin
            cmd.start_session = 1'b1;
            state_next        = ST_IDLE;
          end else if (!sts.started && sts.session_on) begin
            cmd.stop_session = 1'b1;
            state_next       = ST_EMIT_STOP;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          cmd.set_last = 1'b1;
          state_next   = sts.session_on ? ST_LOOP : ST_IDLE;
        end
      end
      ST_LOOP: begin
        // one missed window per cycle
        if (!sts.error_latched && sts.past_close) begin
          cmd.miss_step = 1'b1;
        end else if (sts.trig && !sts.error_latched && !sts.before_open) begin
          state_next = ST_EMIT_MATCH;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT_STOP: begin
        if (sts.out_free) begin
          cmd.load_out    = 1'b1;
          cmd.out_mapping = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      ST_EMIT_MATCH: begin
        if (sts.out_free) begin
          cmd.load_out     = 1'b1;
          cmd.out_mapping  = 1'b1;
          cmd.match_update = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/sttw_dp.sv
// Datapath of the sync trigger window tracker: item capture, window state,
// saturating window sums, miss counting and the output register.
// Depends on sttw_pkg; driven by sttw_ctrl through cmd_t / sts_t.
`default_nettype none

module sttw_dp
  import sttw_pkg::*;
#(
  parameter int TIME_BITS  = DEF_TIME_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cfg_t                   cfg,
  input  wire cmd_t                   cmd,
  output sts_t                        sts,
  input  wire logic                   in_op,
  input  wire logic [IN_TIME_W-1:0]   in_time,
  input  wire logic                   in_trig,
  input  wire logic                   in_started,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_mapping,
  output logic      [DEV_TIME_W-1:0]  out_time,
  output logic      [SECS_W-1:0]      out_secs
);

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [OFFS_W-1:0]    b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + (TIME_BITS+1)'(b);
    return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

  logic                  item_op;
  logic [TIME_BITS-1:0]  item_t;
  logic                  item_trig;
  logic                  item_started;

  logic                  session_on;
  logic [TIME_BITS-1:0]  last_time;
  logic [TIME_BITS-1:0]  win_open;
  logic [TIME_BITS-1:0]  win_close;
  logic [COUNT_BITS-1:0] trigger_number;
  logic [MISS_W-1:0]     miss_count;
  logic                  error_latched;

  logic [MISS_W-1:0]     miss_inc;
  logic                  hit_limit;

  assign miss_inc  = (miss_count == MISS_SAT) ? MISS_SAT : miss_count + 1'b1;
  assign hit_limit = (miss_inc >= MISS_W'(cfg.miss_limit));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_op      <= in_op;
      item_t       <= TIME_BITS'(in_time);
      item_trig    <= in_trig;
      item_started <= in_started;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      session_on     <= 1'b0;
      last_time      <= '0;
      win_open       <= '0;
      win_close      <= '0;
      trigger_number <= '0;
      miss_count     <= '0;
      error_latched  <= 1'b0;
    end else begin
      if (cmd.set_last) begin
        last_time <= item_t;
      end
      if (cmd.start_session) begin
        session_on     <= 1'b1;
        win_open       <= sat_add(last_time, cfg.open_offset);
        win_close      <= sat_add(last_time, cfg.close_offset);
        trigger_number <= COUNT_BITS'(1);
        miss_count     <= '0;
        error_latched  <= 1'b0;
      end
      if (cmd.stop_session) begin
        session_on <= 1'b0;
      end
      if (cmd.miss_step) begin
        miss_count <= miss_inc;
        if (hit_limit) begin
          error_latched <= 1'b1;
        end else begin
          trigger_number <= trigger_number + 1'b1;
          win_open       <= sat_add(win_open, cfg.miss_period);
          win_close      <= sat_add(win_close, cfg.miss_period);
        end
      end
      if (cmd.match_update) begin
        miss_count     <= '0;
        trigger_number <= trigger_number + 1'b1;
        win_open       <= sat_add(item_t, cfg.open_offset);
        win_close      <= sat_add(item_t, cfg.close_offset);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_mapping <= cmd.out_mapping;
      out_time    <= cmd.out_mapping ? DEV_TIME_W'(item_t) : '0;
      out_secs    <= cmd.out_mapping ? SECS_W'(trigger_number) : '0;
    end
  end

  always_comb begin
    sts.op            = item_op;
    sts.started       = item_started;
    sts.trig          = item_trig;
    sts.session_on    = session_on;
    sts.error_latched = error_latched;
    sts.past_close    = (item_t > win_close);
    sts.before_open   = (item_t < win_open);
    sts.out_free      = !out_valid || out_ready;
  end

  a_match_clears_miss: assert property (@(posedge clk) disable iff (rst)
    cmd.match_update |=> (miss_count == '0))
    else $error("miss count not cleared after a match");

  a_error_from_miss: assert property (@(posedge clk) disable iff (rst)
    $rose(error_latched) |-> $past(cmd.miss_step))
    else $error("error latched without a miss step");

  a_start_number: assert property (@(posedge clk) disable iff (rst)
    cmd.start_session |=> (trigger_number == COUNT_BITS'(1)))
    else $error("trigger number not one after session start");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

### sv/sync_trigger_window_tracker_unit.sv
// Sync trigger window tracker, top level. Instantiates sttw_regs, sttw_ctrl, sttw_dp.
// Session event: a start opens the session; a stop closes it, then loads its transaction
// into the output register. A data sample sets the last time; in a session it then steps
// through each missed window (at most 15) and emits on a match; a full output register
// holds the emit state. A new item is accepted only in idle, after the last one is through.
// Reset (rst, synchronous): session closed, window state zero, registers to defaults.
`default_nettype none

module sync_trigger_window_tracker_unit
  import sttw_pkg::*;
#(
  parameter int TIME_BITS  = DEF_TIME_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // sample_time[47:0], sync_trigger[48],
                                                 // session_started[49], zero pad
  input  wire logic                   s_tuser,   // op
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic      [OUT_TDATA_W-1:0] m_tdata,   // device_time[47:0], session_seconds[79:48]
  output logic                        m_tuser,   // mapping_valid
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_ADDR_W-1:0]  paddr,
  input  wire logic [APB_DATA_W-1:0]  pwdata,
  output logic      [APB_DATA_W-1:0]  prdata,
  output logic                        pready
);

  cfg_t                   cfg;
  cmd_t                   cmd;
  sts_t                   sts;
  logic [DEV_TIME_W-1:0]  out_time;
  logic [SECS_W-1:0]      out_secs;

  sttw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sttw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sttw_dp #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .sts         (sts),
    .in_op       (s_tuser),
    .in_time     (s_tdata[IN_TIME_W-1:0]),
    .in_trig     (s_tdata[IN_TIME_W]),
    .in_started  (s_tdata[IN_TIME_W+1]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_mapping (m_tuser),
    .out_time    (out_time),
    .out_secs    (out_secs)
  );

  assign m_tdata = {out_secs, out_time};

endmodule

`default_nettype wire
